### rtl/tpd_pkg.sv
// ----------------------------------------------------------------------------
// Touch packet decoder package
// Shared types, register indexes, reset values and event codes.
// ----------------------------------------------------------------------------
package tpd_pkg;

	localparam int unsigned CoordW = 14;
	localparam int unsigned HalfW  = 7;
	localparam int unsigned ByteW  = 8;

	typedef enum logic [2:0] {
		REG_START_MIN_X = 3'd0,
		REG_START_MAX_X = 3'd1,
		REG_START_MIN_Y = 3'd2,
		REG_START_MAX_Y = 3'd3,
		REG_REVERSE_Y   = 3'd4,
		REG_CLICK_AREA  = 3'd5,
		REG_CLICK_PAUSE = 3'd6
	} reg_idx_t;

	localparam logic [CoordW-1:0] RST_START_MIN = 14'd500;
	localparam logic [CoordW-1:0] RST_START_MAX = 14'd1500;
	localparam logic              RST_REVERSE_Y = 1'b1;
	localparam logic [ByteW-1:0]  RST_CLICK_AREA  = 8'd5;
	localparam logic [ByteW-1:0]  RST_CLICK_PAUSE = 8'd1;
	localparam logic [ByteW-1:0]  TICK_MAX = 8'd255;

	localparam logic       MODE_PACKET = 1'b0;
	localparam logic       MODE_TICK   = 1'b1;
	localparam logic       EVT_MOTION  = 1'b0;
	localparam logic       EVT_BUTTON  = 1'b1;
	localparam logic [1:0] BTN_NONE    = 2'd0;
	localparam logic [1:0] BTN_LEFT    = 2'd1;
	localparam logic [1:0] BTN_RIGHT   = 2'd3;

	// What the back end has to emit for one packet.
	typedef enum logic [1:0] {
		PLAN_MOTION  = 2'd0,   // motion only
		PLAN_RELEASE = 2'd1,   // motion, held button up
		PLAN_PRESS   = 2'd2,   // motion, button 1 down
		PLAN_CLICK   = 2'd3    // motion, button 1 up, button 3 down
	} plan_t;

	typedef struct packed {
		plan_t             plan;
		logic [1:0]        rel_button;
		logic [CoordW-1:0] pos_x;
		logic [CoordW-1:0] pos_y;
	} plan_entry_t;

	typedef struct packed {
		logic             reverse_y;
		logic [ByteW-1:0] click_area;
		logic [ByteW-1:0] click_pause;
	} cfg_t;

	typedef struct packed {
		logic              min_x;
		logic              max_x;
		logic              min_y;
		logic              max_y;
		logic [CoordW-1:0] value;
	} bound_load_t;

endpackage

### rtl/tpd_pkt_if.sv
// ----------------------------------------------------------------------------
// Touch packet channel
// Valid/ready channel that carries one packet or tick item.
// ----------------------------------------------------------------------------
interface tpd_pkt_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic       touch;
	logic [6:0] x_high;
	logic [6:0] x_low;
	logic [6:0] y_high;
	logic [6:0] y_low;

	modport source (output valid, mode, touch, x_high, x_low, y_high, y_low, input ready);
	modport sink   (input valid, mode, touch, x_high, x_low, y_high, y_low, output ready);
endinterface

### rtl/tpd_evt_if.sv
// ----------------------------------------------------------------------------
// Event channel
// Valid/ready channel that carries one motion or button event item.
// ----------------------------------------------------------------------------
interface tpd_evt_if;
	logic        valid;
	logic        ready;
	logic        event_kind;
	logic [1:0]  button_id;
	logic        pressed;
	logic [13:0] pos_x;
	logic [13:0] pos_y;
	logic        last;

	modport source (output valid, event_kind, button_id, pressed, pos_x, pos_y, last,
		input ready);
	modport sink   (input valid, event_kind, button_id, pressed, pos_x, pos_y, last,
		output ready);
endinterface

### rtl/tpd_front.sv
// ----------------------------------------------------------------------------
// Touch decoder front end
// Accepts items, widens the calibration bounds, optionally mirrors y, runs
// the button machine, then pushes one plan entry per packet into the queue.
// ----------------------------------------------------------------------------
module tpd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	tpd_pkt_if.sink              pkt,
	input  tpd_pkg::cfg_t        cfg,
	input  tpd_pkg::bound_load_t bound_load,
	output logic                 push,
	output tpd_pkg::plan_entry_t push_entry,
	input  logic                 push_ready
);
	import tpd_pkg::*;

	logic [CoordW-1:0] bmin_x_q, bmax_x_q, bmin_y_q, bmax_y_q;
	logic [CoordW-1:0] x_in, y_in, nmin_y, nmax_y, y_mirror;
	logic              accept, accept_pkt;

	logic              valid_s1;
	logic              mode_s1, touch_s1;
	logic [CoordW-1:0] x_s1, y_s1;

	logic [1:0]        held_q;
	logic [CoordW-1:0] org_x_q, org_y_q;
	logic [ByteW-1:0]  ticks_q;
	logic [CoordW-1:0] dx, dy;
	logic              near, advance;
	plan_t             plan;

	assign x_in = {pkt.x_high, pkt.x_low};
	assign y_in = {pkt.y_high, pkt.y_low};

	assign advance    = valid_s1 && (mode_s1 == MODE_TICK || push_ready);
	assign pkt.ready  = !valid_s1 || advance;
	assign accept     = pkt.valid && pkt.ready;
	assign accept_pkt = accept && pkt.mode == MODE_PACKET;

	// Mirror against the bounds as they stand after this packet widened them.
	assign nmin_y   = (y_in < bmin_y_q) ? y_in : bmin_y_q;
	assign nmax_y   = (y_in > bmax_y_q) ? y_in : bmax_y_q;
	assign y_mirror = nmax_y - y_in + nmin_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bmin_x_q <= RST_START_MIN;
			bmax_x_q <= RST_START_MAX;
			bmin_y_q <= RST_START_MIN;
			bmax_y_q <= RST_START_MAX;
		end else begin
			if (bound_load.min_x) begin
				bmin_x_q <= bound_load.value;
			end else if (accept_pkt && x_in < bmin_x_q) begin
				bmin_x_q <= x_in;
			end
			if (bound_load.max_x) begin
				bmax_x_q <= bound_load.value;
			end else if (accept_pkt && x_in > bmax_x_q) begin
				bmax_x_q <= x_in;
			end
			if (bound_load.min_y) begin
				bmin_y_q <= bound_load.value;
			end else if (accept_pkt) begin
				bmin_y_q <= nmin_y;
			end
			if (bound_load.max_y) begin
				bmax_y_q <= bound_load.value;
			end else if (accept_pkt) begin
				bmax_y_q <= nmax_y;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= pkt.mode;
			touch_s1 <= pkt.touch;
			x_s1     <= x_in;
			y_s1     <= cfg.reverse_y ? y_mirror : y_in;
		end
	end

	assign dx   = (x_s1 >= org_x_q) ? x_s1 - org_x_q : org_x_q - x_s1;
	assign dy   = (y_s1 >= org_y_q) ? y_s1 - org_y_q : org_y_q - y_s1;
	assign near = dx < {{(CoordW-ByteW){1'b0}}, cfg.click_area}
		&& dy < {{(CoordW-ByteW){1'b0}}, cfg.click_area};

	always_comb begin
		plan = PLAN_MOTION;
		if (!touch_s1) begin
			if (held_q != BTN_NONE) begin
				plan = PLAN_RELEASE;
			end
		end else if (held_q == BTN_NONE) begin
			plan = PLAN_PRESS;
		end else if (held_q == BTN_LEFT && near && ticks_q >= cfg.click_pause) begin
			plan = PLAN_CLICK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= BTN_NONE;
			org_x_q <= '0;
			org_y_q <= '0;
			ticks_q <= '0;
		end else if (advance) begin
			if (mode_s1 == MODE_TICK) begin
				if (ticks_q != TICK_MAX) begin
					ticks_q <= ticks_q + 8'd1;
				end
			end else begin
				case (plan)
					PLAN_RELEASE: begin
						held_q  <= BTN_NONE;
						ticks_q <= '0;
					end
					PLAN_PRESS: begin
						held_q  <= BTN_LEFT;
						ticks_q <= '0;
						org_x_q <= x_s1;
						org_y_q <= y_s1;
					end
					PLAN_CLICK: begin
						held_q <= BTN_RIGHT;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign push                  = advance && mode_s1 == MODE_PACKET;
	assign push_entry.plan       = plan;
	assign push_entry.rel_button = held_q;
	assign push_entry.pos_x      = x_s1;
	assign push_entry.pos_y      = y_s1;

endmodule

### rtl/tpd_queue.sv
// ----------------------------------------------------------------------------
// Plan queue
// Small FIFO of plan entries between the front end and the back end.
// ----------------------------------------------------------------------------
module tpd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tpd_pkg::plan_entry_t push_entry,
	output logic                 push_ready,
	input  logic                 pop,
	output logic                 head_valid,
	output tpd_pkg::plan_entry_t head_entry
);
	import tpd_pkg::*;

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast  = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntDepth = CntW'(DEPTH);

	plan_entry_t       mem_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_push, do_pop;

	assign push_ready = count_q != CntDepth;
	assign head_valid = count_q != '0;
	assign head_entry = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/tpd_back.sv
// ----------------------------------------------------------------------------
// Touch decoder back end
// Expands each plan entry into one to three event items, one per cycle
// while evt is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module tpd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  tpd_pkg::plan_entry_t head_entry,
	output logic                 pop,
	tpd_evt_if.source            evt
);
	import tpd_pkg::*;

	logic [1:0]        idx_q, last_idx;
	logic              load, is_last;
	logic              kind, prs;
	logic [1:0]        btn;

	logic              valid_q;
	logic              kind_q, prs_q, last_q;
	logic [1:0]        btn_q;
	logic [CoordW-1:0] x_q, y_q;

	always_comb begin
		case (head_entry.plan)
			PLAN_MOTION: last_idx = 2'd0;
			PLAN_CLICK:  last_idx = 2'd2;
			default:     last_idx = 2'd1;
		endcase
	end

	always_comb begin
		kind = EVT_BUTTON;
		btn  = BTN_NONE;
		prs  = 1'b0;
		if (idx_q == 2'd0) begin
			kind = EVT_MOTION;
		end else begin
			case (head_entry.plan)
				PLAN_RELEASE: begin
					btn = head_entry.rel_button;
				end
				PLAN_PRESS: begin
					btn = BTN_LEFT;
					prs = 1'b1;
				end
				PLAN_CLICK: begin
					// First the left button goes up, then the right one goes down.
					btn = (idx_q == 2'd1) ? BTN_LEFT : BTN_RIGHT;
					prs = idx_q != 2'd1;
				end
				default: begin
				end
			endcase
		end
	end

	assign is_last = idx_q == last_idx;
	assign load    = !valid_q || evt.ready;
	assign pop     = load && head_valid && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			kind_q <= kind;
			btn_q  <= btn;
			prs_q  <= prs;
			x_q    <= head_entry.pos_x;
			y_q    <= head_entry.pos_y;
			last_q <= is_last;
		end
	end

	assign evt.valid      = valid_q;
	assign evt.event_kind = kind_q;
	assign evt.button_id  = btn_q;
	assign evt.pressed    = prs_q;
	assign evt.pos_x      = x_q;
	assign evt.pos_y      = y_q;
	assign evt.last       = last_q;

endmodule

### rtl/touch_packet_decoder_with_long_press_top.sv
// ----------------------------------------------------------------------------
// Touch packet decoder with long-press right-click
// Top level: configuration registers, front end, plan queue and back end.
// ----------------------------------------------------------------------------
// Items arrive on the pkt channel (valid/ready). A packet item (mode 0)
// carries the touch bit and the 7-bit halves of x and y; a tick item
// (mode 1) only advances the saturating hold counter and yields nothing.
// Each packet yields one to three event items on the evt channel: a motion
// event, then the button events of the press, release or long-press click;
// the last field marks the final event of a packet.
// An accepted packet passes the front-end stage register, the plan queue
// and the output register before its first event reaches evt. The front
// end takes one item per cycle while the queue has room, and ticks pass
// only its stage; the back end emits one event per cycle while evt is ready.
// Registers sit on the APB port at byte address 4*i; writes load the start
// bounds into the live calibration bounds at once.
// Reset restores all registers to their defaults, loads the start bounds,
// releases the button machine and empties the queue.
// When evt stalls, the output register holds its item, the queue of
// QUEUE_DEPTH plan entries fills, and then pkt.ready falls.
// ----------------------------------------------------------------------------
module touch_packet_decoder_with_long_press_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	tpd_pkt_if.sink     pkt,
	tpd_evt_if.source   evt
);
	import tpd_pkg::*;

	logic [CoordW-1:0] start_min_x_q, start_max_x_q, start_min_y_q, start_max_y_q;
	logic              reverse_y_q;
	logic [ByteW-1:0]  click_area_q, click_pause_q;

	reg_idx_t          reg_idx;
	logic              wr_en;
	cfg_t              cfg;
	bound_load_t       bound_load;

	logic              push, push_ready, pop, head_valid;
	plan_entry_t       push_entry, head_entry;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_min_x_q <= RST_START_MIN;
			start_max_x_q <= RST_START_MAX;
			start_min_y_q <= RST_START_MIN;
			start_max_y_q <= RST_START_MAX;
			reverse_y_q   <= RST_REVERSE_Y;
			click_area_q  <= RST_CLICK_AREA;
			click_pause_q <= RST_CLICK_PAUSE;
		end else if (wr_en) begin
			case (reg_idx)
				REG_START_MIN_X: start_min_x_q <= pwdata[CoordW-1:0];
				REG_START_MAX_X: start_max_x_q <= pwdata[CoordW-1:0];
				REG_START_MIN_Y: start_min_y_q <= pwdata[CoordW-1:0];
				REG_START_MAX_Y: start_max_y_q <= pwdata[CoordW-1:0];
				REG_REVERSE_Y:   reverse_y_q   <= pwdata[0];
				REG_CLICK_AREA:  click_area_q  <= pwdata[ByteW-1:0];
				REG_CLICK_PAUSE: click_pause_q <= pwdata[ByteW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_START_MIN_X: prdata = {18'd0, start_min_x_q};
			REG_START_MAX_X: prdata = {18'd0, start_max_x_q};
			REG_START_MIN_Y: prdata = {18'd0, start_min_y_q};
			REG_START_MAX_Y: prdata = {18'd0, start_max_y_q};
			REG_REVERSE_Y:   prdata = {31'd0, reverse_y_q};
			REG_CLICK_AREA:  prdata = {24'd0, click_area_q};
			REG_CLICK_PAUSE: prdata = {24'd0, click_pause_q};
			default:         prdata = '0;
		endcase
	end

	// A start-bound write also overwrites the live bound in the front end.
	assign bound_load.min_x = wr_en && reg_idx == REG_START_MIN_X;
	assign bound_load.max_x = wr_en && reg_idx == REG_START_MAX_X;
	assign bound_load.min_y = wr_en && reg_idx == REG_START_MIN_Y;
	assign bound_load.max_y = wr_en && reg_idx == REG_START_MAX_Y;
	assign bound_load.value = pwdata[CoordW-1:0];

	assign cfg.reverse_y   = reverse_y_q;
	assign cfg.click_area  = click_area_q;
	assign cfg.click_pause = click_pause_q;

	tpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt        (pkt),
		.cfg        (cfg),
		.bound_load (bound_load),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	tpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	tpd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.evt        (evt)
	);

endmodule

### verif/touch_packet_decoder_with_long_press_top_tb.sv
// ----------------------------------------------------------------------------
// Touch packet decoder testbench
// Drives packet and tick items through the block under several register
// settings, predicts every motion and button event it should emit and checks
// each event item, field by field, in order of arrival.
// ----------------------------------------------------------------------------
module touch_packet_decoder_with_long_press_top_tb;
	import tpd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Register index 7 has no register behind it; writes there must be ignored.
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int unsigned CoordMax = (1 << CoordW) - 1;

	typedef struct packed {
		logic        mode;
		logic        touch;
		logic [6:0]  x_high;
		logic [6:0]  x_low;
		logic [6:0]  y_high;
		logic [6:0]  y_low;
	} touch_item_t;

	typedef struct packed {
		logic              event_kind;
		logic [1:0]        button_id;
		logic              pressed;
		logic [CoordW-1:0] pos_x;
		logic [CoordW-1:0] pos_y;
		logic              last;
	} touch_event_t;

	// Tracks calibration bounds and the button machine, and keeps the queue
	// of events the block still owes us.
	class gesture_tracker;
		logic [CoordW-1:0] start_min_x, start_max_x, start_min_y, start_max_y;
		logic              rev_y;
		logic [ByteW-1:0]  area, pause;
		logic [CoordW-1:0] lo_x, hi_x, lo_y, hi_y, org_x, org_y;
		logic [1:0]        held;
		logic [ByteW-1:0]  ticks;
		touch_event_t      pending_events[$];
		int                errors, checked, packets, tick_count;

		function new();
			start_min_x = RST_START_MIN;
			start_max_x = RST_START_MAX;
			start_min_y = RST_START_MIN;
			start_max_y = RST_START_MAX;
			rev_y = RST_REVERSE_Y;
			area = RST_CLICK_AREA;
			pause = RST_CLICK_PAUSE;
			lo_x = start_min_x;
			hi_x = start_max_x;
			lo_y = start_min_y;
			hi_y = start_max_y;
			org_x = '0;
			org_y = '0;
			held = BTN_NONE;
			ticks = '0;
			errors = 0;
			checked = 0;
			packets = 0;
			tick_count = 0;
		endfunction

		// A start register write also reloads the matching live bound.
		function void write_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_START_MIN_X: begin
					start_min_x = value[CoordW-1:0];
					lo_x = value[CoordW-1:0];
				end
				REG_START_MAX_X: begin
					start_max_x = value[CoordW-1:0];
					hi_x = value[CoordW-1:0];
				end
				REG_START_MIN_Y: begin
					start_min_y = value[CoordW-1:0];
					lo_y = value[CoordW-1:0];
				end
				REG_START_MAX_Y: begin
					start_max_y = value[CoordW-1:0];
					hi_y = value[CoordW-1:0];
				end
				REG_REVERSE_Y:   rev_y = value[0];
				REG_CLICK_AREA:  area = value[ByteW-1:0];
				REG_CLICK_PAUSE: pause = value[ByteW-1:0];
				default: ;
			endcase
		endfunction

		function void check_reg(reg_idx_t idx, logic [31:0] got);
			logic [31:0] want;
			case (idx)
				REG_START_MIN_X: want = 32'(start_min_x);
				REG_START_MAX_X: want = 32'(start_max_x);
				REG_START_MIN_Y: want = 32'(start_min_y);
				REG_START_MAX_Y: want = 32'(start_max_y);
				REG_REVERSE_Y:   want = 32'(rev_y);
				REG_CLICK_AREA:  want = 32'(area);
				default:         want = 32'(pause);
			endcase
			if (got !== want) begin
				$error("register %s: expected %0d, got %0d", idx.name(), want, got);
				errors++;
			end
		endfunction

		function logic [CoordW-1:0] span(logic [CoordW-1:0] a, logic [CoordW-1:0] b);
			return (a > b) ? a - b : b - a;
		endfunction

		// Works out the events of one accepted item.
		function void accept(touch_item_t it);
			logic [CoordW-1:0] x, y;
			touch_event_t      batch[3];
			int                n;
			n = 0;
			if (it.mode == MODE_TICK) begin
				if (ticks != TICK_MAX)
					ticks++;
				tick_count++;
				return;
			end
			packets++;
			x = {it.x_high, it.x_low};
			y = {it.y_high, it.y_low};
			if (x < lo_x) lo_x = x;
			if (x > hi_x) hi_x = x;
			if (y < lo_y) lo_y = y;
			if (y > hi_y) hi_y = y;
			if (rev_y)
				y = hi_y - y + lo_y;
			batch[n++] = '{EVT_MOTION, BTN_NONE, 1'b0, x, y, 1'b0};
			if (!it.touch) begin
				if (held != BTN_NONE) begin
					batch[n++] = '{EVT_BUTTON, held, 1'b0, x, y, 1'b0};
					held = BTN_NONE;
					ticks = '0;
				end
			end else if (held == BTN_NONE) begin
				batch[n++] = '{EVT_BUTTON, BTN_LEFT, 1'b1, x, y, 1'b0};
				held = BTN_LEFT;
				ticks = '0;
				org_x = x;
				org_y = y;
			end else if (held == BTN_LEFT && span(x, org_x) < CoordW'(area) &&
					span(y, org_y) < CoordW'(area) && ticks >= pause) begin
				// Long steady press turns into a right click.
				batch[n++] = '{EVT_BUTTON, BTN_LEFT, 1'b0, x, y, 1'b0};
				batch[n++] = '{EVT_BUTTON, BTN_RIGHT, 1'b1, x, y, 1'b0};
				held = BTN_RIGHT;
			end
			batch[n-1].last = 1'b1;
			for (int i = 0; i < n; i++)
				pending_events.push_back(batch[i]);
		endfunction

		function void compare(string name, int want, int got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void take_event(touch_event_t got);
			touch_event_t want;
			if (pending_events.size() == 0) begin
				$error("event item with nothing expected: kind %0d button %0d x %0d y %0d",
					got.event_kind, got.button_id, got.pos_x, got.pos_y);
				errors++;
				return;
			end
			want = pending_events.pop_front();
			checked++;
			compare("event_kind", want.event_kind, got.event_kind);
			compare("button_id", want.button_id, got.button_id);
			compare("pressed", want.pressed, got.pressed);
			compare("pos_x", want.pos_x, got.pos_x);
			compare("pos_y", want.pos_y, got.pos_y);
			compare("last", want.last, got.last);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        quiet;
	int          items_sent;
	int          settings_used;

	tpd_pkt_if pkt_ch ();
	tpd_evt_if evt_ch ();

	gesture_tracker tracker;

	touch_packet_decoder_with_long_press_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pkt     (pkt_ch),
		.evt     (evt_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The event sink stalls now and then, except during the quiet stretch.
	always @(negedge clk) begin
		evt_ch.ready <= quiet || ($urandom_range(0, 99) >= 13);
	end

	// Every accepted event item is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && evt_ch.valid && evt_ch.ready) begin
			tracker.take_event('{evt_ch.event_kind, evt_ch.button_id, evt_ch.pressed,
				evt_ch.pos_x, evt_ch.pos_y, evt_ch.last});
		end
	end

	// APB write: a setup phase, then an access phase; the register takes the
	// value at the edge where the access phase meets pready.
	task automatic apb_write(logic [2:0] idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.write_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read(reg_idx_t idx);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.check_reg(idx, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic read_back_all();
		for (int i = 0; i <= int'(REG_CLICK_PAUSE); i++)
			apb_read(reg_idx_t'(i));
	endtask

	// Writes every register, then reads them all back.
	task automatic write_all(logic [31:0] min_x, logic [31:0] max_x, logic [31:0] min_y,
			logic [31:0] max_y, logic [31:0] rev, logic [31:0] area,
			logic [31:0] pause);
		apb_write(REG_START_MIN_X, min_x);
		apb_write(REG_START_MAX_X, max_x);
		apb_write(REG_START_MIN_Y, min_y);
		apb_write(REG_START_MAX_Y, max_y);
		apb_write(REG_REVERSE_Y, rev);
		apb_write(REG_CLICK_AREA, area);
		apb_write(REG_CLICK_PAUSE, pause);
		read_back_all();
		settings_used++;
	endtask

	// Offers one item; the predictor learns of it at the edge it is taken.
	task automatic send_item(touch_item_t it);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 13) begin
			pkt_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pkt_ch.valid <= 1'b1;
		pkt_ch.mode <= it.mode;
		pkt_ch.touch <= it.touch;
		pkt_ch.x_high <= it.x_high;
		pkt_ch.x_low <= it.x_low;
		pkt_ch.y_high <= it.y_high;
		pkt_ch.y_low <= it.y_low;
		do @(posedge clk); while (!pkt_ch.ready);
		tracker.accept(it);
		items_sent++;
	endtask

	task automatic send_packet(logic touch, logic [CoordW-1:0] x, logic [CoordW-1:0] y);
		send_item('{MODE_PACKET, touch, x[13:7], x[6:0], y[13:7], y[6:0]});
	endtask

	// The coordinate and touch fields of a tick carry random junk.
	task automatic send_tick();
		send_item('{MODE_TICK, 1'($urandom), 7'($urandom), 7'($urandom),
			7'($urandom), 7'($urandom)});
	endtask

	// Waits until the block owes nothing and has had time to finish ticks.
	task automatic settle();
		@(negedge clk);
		pkt_ch.valid <= 1'b0;
		while (tracker.pending_events.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [CoordW-1:0] jitter(logic [CoordW-1:0] base, int s);
		int v;
		v = int'(base) + int'($urandom_range(0, 2 * s)) - s;
		if (v < 0) v = 0;
		if (v > int'(CoordMax)) v = int'(CoordMax);
		return CoordW'(v);
	endfunction

	// Press, up to four holds jittered around the origin with ticks in between, release.
	task automatic run_gesture();
		logic [CoordW-1:0] px, py;
		int                s;
		px = CoordW'($urandom);
		py = CoordW'($urandom);
		case ($urandom_range(0, 2))
			0: s = 2;
			1: s = int'(tracker.area);
			default: s = 300;
		endcase
		send_packet(1'b1, px, py);
		repeat ($urandom_range(0, 4)) begin
			repeat ($urandom_range(0, 3)) send_tick();
			send_packet(1'b1, jitter(px, s), jitter(py, s));
		end
		repeat ($urandom_range(0, 1)) send_tick();
		send_packet(1'b0, jitter(px, s), jitter(py, s));
	endtask

	// Mostly whole gestures, the rest stray packets and ticks.
	task automatic run_random(int count);
		int target;
		target = items_sent + count;
		while (items_sent < target) begin
			case ($urandom_range(0, 19))
				0, 1, 2: send_packet(1'($urandom), CoordW'($urandom), CoordW'($urandom));
				3, 4, 5: send_tick();
				default: run_gesture();
			endcase
		end
	endtask

	// A timeout means the block stopped taking or giving items.
	initial begin
		#3ms;
		$display("touch_packet_decoder_with_long_press_top_tb failed");
		$finish;
	end

	initial begin
		logic [CoordW-1:0] sx, sy;
		tracker = new();
		items_sent = 0;
		settings_used = 1;
		quiet = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pkt_ch.valid = 1'b0;
		pkt_ch.mode = MODE_PACKET;
		pkt_ch.touch = 1'b0;
		pkt_ch.x_high = '0;
		pkt_ch.x_low = '0;
		pkt_ch.y_high = '0;
		pkt_ch.y_low = '0;
		evt_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values first, then a directed walk through the button machine
		// under the default settings (mirrored y, area 5, pause 1).
		read_back_all();
		send_packet(1'b0, '0, '0);                 // widens both minimum bounds to zero
		send_packet(1'b0, CoordW'(CoordMax), CoordW'(CoordMax)); // widens both maximums
		send_item('{MODE_TICK, 1'b1, 7'h7f, 7'h7f, 7'h7f, 7'h7f});
		send_packet(1'b1, 14'd800, 14'd900);       // press: button 1 down
		send_packet(1'b1, 14'd800, 14'd900);       // steady, but the pause has not passed
		send_tick();
		send_packet(1'b1, 14'd802, 14'd897);       // long press: button 1 up, button 3 down
		send_packet(1'b1, 14'd802, 14'd897);       // button 3 held: motion only
		send_packet(1'b0, 14'd810, 14'd900);       // release: button 3 up
		send_packet(1'b1, 14'd2000, 14'd3000);
		send_tick();
		send_packet(1'b1, 14'd2005, 14'd3000);     // x off by exactly the area: no click
		send_packet(1'b1, 14'd2004, 14'd3004);     // just inside on both axes: click
		send_packet(1'b0, 14'd2004, 14'd3004);
		send_packet(1'b1, 14'd100, 14'd100);
		send_packet(1'b0, 14'd100, 14'd100);       // release of a plain press: button 1 up
		send_packet(1'b0, 14'd100, 14'd100);       // nothing held: motion only
		send_tick();
		send_tick();
		settle();

		// Inverted start bounds, no mirroring, zero click area and zero pause.
		// Upper bits of the written words must be dropped.
		write_all(32'hffff_ffff, 32'h0000_0000, 32'h0000_7fff, 32'hffff_c000,
			32'hffff_fffe, 32'hffff_ff00, 32'h0000_0000);
		apb_write(REG_UNUSED, $urandom());
		read_back_all();
		run_random(45);
		settle();

		// Widest bounds, widest area, zero pause; neither side stalls here.
		quiet = 1'b1;
		write_all(32'h0, CoordMax, 32'h0, CoordMax, 32'h1, 32'hff, 32'h0);
		run_random(45);
		settle();
		quiet = 1'b0;

		// Long pause: the click comes only once enough ticks have piled up.
		write_all($urandom(), $urandom(), $urandom(), $urandom(), 32'h1, 32'd20, 32'd30);
		sx = CoordW'($urandom);
		sy = CoordW'($urandom);
		send_packet(1'b1, sx, sy);
		repeat (29) send_tick();
		send_packet(1'b1, sx, sy);                 // one tick short of the pause
		repeat (10) send_tick();
		send_packet(1'b1, sx, sy);                 // pause passed: click
		send_packet(1'b0, sx, sy);
		settle();

		// Random settings with small areas and pauses so that clicks happen.
		write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
			($urandom() & 32'hffff_ff00) | $urandom_range(2, 40), $urandom_range(0, 3));
		run_random(55);

		settle();
		repeat (10) @(posedge clk);
		$display("Ran %0d packets and %0d ticks under %0d register settings.",
			tracker.packets, tracker.tick_count, settings_used);
		$display("Checked %0d event items, %0d problems found.", tracker.checked,
			tracker.errors);
		if (tracker.errors == 0)
			$display("touch_packet_decoder_with_long_press_top_tb passed");
		else
			$display("touch_packet_decoder_with_long_press_top_tb failed");
		$finish;
	end

endmodule

### filelist.f
rtl/tpd_pkg.sv
rtl/tpd_pkt_if.sv
rtl/tpd_evt_if.sv
rtl/tpd_front.sv
rtl/tpd_queue.sv
rtl/tpd_back.sv
rtl/touch_packet_decoder_with_long_press_top.sv
verif/touch_packet_decoder_with_long_press_top_tb.sv
